### design/counting_semaphore_fifo_wait_assert.svh
// Assertion helpers used by the checker file.
// Both forms sample on the rising edge of clk and are off while rst_n is low.
`ifndef COUNTING_SEMAPHORE_FIFO_WAIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAIT_ASSERT_SVH

// Same-cycle implication.
`define CSFW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication; cons may open with a further delay.
`define CSFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

### design/csfw_pkg.sv
`default_nettype none

package csfw_pkg;

  localparam int CountW = 16;
  localparam int TidW   = 8;
  localparam int WaitW  = 5;

  typedef logic [CountW-1:0] csfw_count_t;
  typedef logic [TidW-1:0]   csfw_tid_t;
  typedef logic [WaitW-1:0]  csfw_waiters_t;

  localparam logic FUNC_TAKE = 1'b0;
  localparam logic FUNC_GIVE = 1'b1;

  typedef enum logic [2:0] {
    OUT_GRANTED = 3'd0,
    OUT_QUEUED  = 3'd1,
    OUT_RAISED  = 3'd2,
    OUT_WOKEN   = 3'd3,
    OUT_REJECT  = 3'd4
  } csfw_outcome_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } csfw_state_t;

  typedef struct packed {
    logic      func;
    csfw_tid_t caller_thread;
  } csfw_in_t;

  typedef struct packed {
    csfw_outcome_t outcome;
    csfw_tid_t     woken_thread;
    csfw_count_t   count_now;
    csfw_waiters_t waiters_now;
  } csfw_out_t;

  // Queue control from the sequencer.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } csfw_qctl_t;

  // Queue status seen by the sequencer.
  typedef struct packed {
    logic          empty;
    logic          full;
    csfw_waiters_t waiters;
  } csfw_qstat_t;

endpackage

`default_nettype wire

### design/csfw_queue.sv
`default_nettype none

module csfw_queue #(
  parameter int WAIT_DEPTH = 16,
  parameter int ID_BITS    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire csfw_pkg::csfw_qctl_t ctl,
  input  wire logic [ID_BITS-1:0]   push_id,
  output logic [ID_BITS-1:0]        head_id,
  output csfw_pkg::csfw_qstat_t     stat
);

  localparam int PtrW  = $clog2(WAIT_DEPTH);
  localparam int FillW = $clog2(WAIT_DEPTH + 1);
  localparam logic [PtrW-1:0]  LastIdx = PtrW'(WAIT_DEPTH - 1);
  localparam logic [FillW-1:0] FullCnt = FillW'(WAIT_DEPTH);

  logic [ID_BITS-1:0] mem [WAIT_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;
  logic [PtrW-1:0]    head_r, head_nxt;
  logic [PtrW-1:0]    tail_r, tail_nxt;
  logic [FillW-1:0]   fill_r, fill_nxt;

  // The head entry is read every cycle; the sequencer uses the registered copy.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_id;
    end
    rd_data_r <= mem[head_r];
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
    end else begin
      if (ctl.push) begin
        tail_nxt = (tail_r == LastIdx) ? '0 : tail_r + PtrW'(1);
      end
      if (ctl.pop) begin
        head_nxt = (head_r == LastIdx) ? '0 : head_r + PtrW'(1);
      end
      if (ctl.push && !ctl.pop) begin
        fill_nxt = fill_r + FillW'(1);
      end else if (ctl.pop && !ctl.push) begin
        fill_nxt = fill_r - FillW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign head_id      = rd_data_r;
  assign stat.empty   = (fill_r == '0);
  assign stat.full    = (fill_r == FullCnt);
  assign stat.waiters = csfw_pkg::csfw_waiters_t'(fill_r);

endmodule

`default_nettype wire

### design/counting_semaphore_fifo_wait.sv
`default_nettype none

// Counting semaphore with a FIFO of waiting thread IDs. A request is taken
// when start is high and busy is low; busy then stays high for one execute
// cycle, and no new request is taken until that cycle is over. The execute
// cycle waits on the registered read of the wait-queue memory, whose head
// entry is read at the accepting edge and used in the execute cycle.
// Exactly one result follows each request: out_strobe is high for one cycle,
// the cycle after the execute cycle, and the result cannot be held off, so
// the receiver must take it then. A take with a nonzero count is granted; at
// zero count the caller is queued. A give hands the resource straight to the
// oldest waiter, or raises the count if nobody waits. A full queue or a
// count at 65535 rejects the request and changes nothing. A write on the cfg
// channel (accepted while busy is low) re-creates the semaphore: the count
// takes the written value and the queue is emptied. After reset the count is
// zero and the queue is empty.
module counting_semaphore_fifo_wait #(
  parameter int WAIT_DEPTH     = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire csfw_pkg::csfw_in_t    in_data,
  output logic                       out_strobe,
  output csfw_pkg::csfw_out_t        out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire csfw_pkg::csfw_count_t cfg_data
);

  // Only the low ID bits that fit the field are stored.
  localparam int IdW = (THREAD_ID_BITS < csfw_pkg::TidW) ? THREAD_ID_BITS
                                                          : csfw_pkg::TidW;

  csfw_pkg::csfw_state_t   state_r, state_nxt;
  csfw_pkg::csfw_in_t      req_r;
  csfw_pkg::csfw_count_t   count_r, count_nxt;
  logic                    out_strobe_r;
  csfw_pkg::csfw_out_t     out_data_r, result;
  csfw_pkg::csfw_qctl_t    qctl;
  csfw_pkg::csfw_qstat_t   qstat;
  csfw_pkg::csfw_outcome_t outcome;
  logic [IdW-1:0]          head_id;
  logic                    accept, exec, cfg_we, do_push, do_pop;

  assign busy      = (state_r == csfw_pkg::ST_EXEC);
  assign accept    = start && !busy;
  assign exec      = busy;
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csfw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csfw_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = csfw_pkg::ST_EXEC;
        end
      end
      csfw_pkg::ST_EXEC: begin
        state_nxt = csfw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = csfw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  // Decision for the request held in req_r, using the head entry read at
  // the accepting edge.
  always_comb begin
    count_nxt = count_r;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    outcome   = csfw_pkg::OUT_REJECT;
    if (req_r.func == csfw_pkg::FUNC_TAKE) begin
      priority if (count_r != '0) begin
        count_nxt = count_r - csfw_pkg::csfw_count_t'(1);
        outcome   = csfw_pkg::OUT_GRANTED;
      end else if (!qstat.full) begin
        do_push = 1'b1;
        outcome = csfw_pkg::OUT_QUEUED;
      end else begin
        outcome = csfw_pkg::OUT_REJECT;
      end
    end else begin
      priority if (!qstat.empty) begin
        do_pop  = 1'b1;
        outcome = csfw_pkg::OUT_WOKEN;
      end else if (count_r != '1) begin
        count_nxt = count_r + csfw_pkg::csfw_count_t'(1);
        outcome   = csfw_pkg::OUT_RAISED;
      end else begin
        outcome = csfw_pkg::OUT_REJECT;
      end
    end

    result.outcome      = outcome;
    result.woken_thread = do_pop ? csfw_pkg::csfw_tid_t'(head_id) : '0;
    result.count_now    = count_nxt;
    result.waiters_now  = qstat.waiters
                          + csfw_pkg::csfw_waiters_t'(do_push)
                          - csfw_pkg::csfw_waiters_t'(do_pop);
  end

  assign qctl.clear = cfg_we;
  assign qctl.push  = exec && do_push;
  assign qctl.pop   = exec && do_pop;

  csfw_queue #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .ID_BITS    (IdW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (qctl),
    .push_id (req_r.caller_thread[IdW-1:0]),
    .head_id (head_id),
    .stat    (qstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end else if (exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= result;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

### design/csfw_checker.sv
`default_nettype none

`include "counting_semaphore_fifo_wait_assert.svh"

module csfw_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_strobe,
  input wire csfw_pkg::csfw_out_t out_data
);

  // An accepted request yields its result strobe after the execute cycle.
  `CSFW_ASSERT_NEXT(a_result_follows, start && !busy, ##1 out_strobe, "missing result")

  `CSFW_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "busy held longer than one cycle")

  // Waiters and a nonzero count never exist together.
  `CSFW_ASSERT_IMPL(a_woken_zero_count, out_strobe && out_data.outcome == csfw_pkg::OUT_WOKEN, out_data.count_now == '0, "wake with nonzero count")

  `CSFW_ASSERT_IMPL(a_queued_state, out_strobe && out_data.outcome == csfw_pkg::OUT_QUEUED, (out_data.count_now == '0 && out_data.waiters_now != '0), "bad state after queueing")

  `CSFW_ASSERT_IMPL(a_woken_id_clear, out_strobe && out_data.outcome != csfw_pkg::OUT_WOKEN, out_data.woken_thread == '0, "thread ID without a wake")

endmodule

bind counting_semaphore_fifo_wait csfw_checker u_csfw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
